// ===== rtl/core/gmv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmv_pkg
// Shared constants and controller/datapath interface types for the group
// mean and variance block.
// ----------------------------------------------------------------------------
package gmv_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_GROUP_DEF   = 65536;
   localparam int FRAC_BITS_DEF   = 16;

   // group length register and sample counter width
   localparam int LEN_W  = 17;
   // result word field widths
   localparam int MEAN_W = 32;
   localparam int VAR_W  = 47;

   typedef struct packed {
      logic idle;        // controller has no group in flight
      logic mul1;        // magnitude, n*n, low partial product
      logic mul2;        // sum^2, high partial product
      logic sub;         // form n*sumsq - sum^2
      logic div_start;   // launch both dividers
      logic load_out;    // move quotients into the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic group_done;  // snapshot of a finished group is being written
      logic div_busy;    // a divider is still iterating
   } dp_status_type;

endpackage

// ===== rtl/core/gmv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmv_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;
   logic             fit;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      diff   = rem_sh - {1'b0, den_ff};
      fit    = ~diff[DEN_W];
      // remainder stays below den, so it fits DEN_W bits either way
      rem_in = fit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], fit};
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = num_ff;

endmodule

// ===== rtl/core/gmv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmv_ctrl
// Sequencer for the end-of-group math: multiply, subtract, divide, and
// hand-off into the result register.
// ----------------------------------------------------------------------------
module gmv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  gmv_pkg::dp_status_type status,
   output gmv_pkg::ctrl_cmd_type cmd,
   input  logic                  rsp_ready,
   output logic                  rsp_valid
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_SUB  = 3'd3;
   localparam logic [2:0] ST_GO   = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (status.group_done) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUB;
         ST_SUB:  state_in = ST_GO;
         ST_GO:   state_in = ST_DIV;
         ST_DIV:  if (!status.div_busy) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.idle      = (state_ff == ST_IDLE);
      cmd.mul1      = (state_ff == ST_MUL1);
      cmd.mul2      = (state_ff == ST_MUL2);
      cmd.sub       = (state_ff == ST_SUB);
      cmd.div_start = (state_ff == ST_GO);
      cmd.load_out  = (state_ff == ST_DONE) & out_free;
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/gmv_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmv_dp
// Datapath: group length register, sample accumulators, group snapshot,
// multi-cycle multiply/subtract, the two dividers and the result register.
// ----------------------------------------------------------------------------
module gmv_dp #(
   parameter int SAMPLE_BITS = gmv_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_GROUP   = gmv_pkg::MAX_GROUP_DEF,
   parameter int FRAC_BITS   = gmv_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gmv_pkg::ctrl_cmd_type               cmd,
   output gmv_pkg::dp_status_type              status,
   input  logic                                csr_valid,
   input  logic [gmv_pkg::LEN_W-1:0]           csr_group_length,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic signed [gmv_pkg::MEAN_W-1:0]   rsp_mean_value,
   output logic [gmv_pkg::VAR_W-1:0]           rsp_variance_value
);

   localparam int LEN_W   = gmv_pkg::LEN_W;
   localparam int MEAN_W  = gmv_pkg::MEAN_W;
   localparam int VAR_W   = gmv_pkg::VAR_W;
   localparam int SSQ_W   = 2 * SAMPLE_BITS - 1;          // one sample squared
   localparam int SUM_W   = SAMPLE_BITS + LEN_W;          // signed running sum
   localparam int MAG_W   = SUM_W;                        // |sum|
   localparam int SQ_W    = 2 * SAMPLE_BITS + LEN_W - 2;  // running sum of squares
   localparam int LO_W    = (SQ_W + 1) / 2;
   localparam int HI_W    = SQ_W - LO_W;
   localparam int PROD_W  = LEN_W + SQ_W;                 // n * sumsq
   localparam int NN_W    = 2 * LEN_W;
   localparam int MNUM_W  = MAG_W + FRAC_BITS;
   localparam int VNUM_W  = PROD_W + FRAC_BITS;
   localparam logic [31:0] MAX_G = 32'(MAX_GROUP);

   // ---------------- group length register ----------------
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
      end else if (csr_valid) begin
         len_ff <= csr_group_length;
      end
   end

   always_comb begin
      if (len_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (32'(len_ff) > MAX_G) begin
         n_eff = LEN_W'(MAX_GROUP);
      end else begin
         n_eff = len_ff;
      end
   end

   // ---------------- accept stage: count and square ----------------
   logic [LEN_W-1:0]               cnt_ff;
   logic [LEN_W-1:0]               cnt_inc;
   logic                           last_now;
   logic                           accept;
   logic signed [2*SAMPLE_BITS-1:0] sq_full;

   assign cnt_inc  = cnt_ff + LEN_W'(1);
   assign last_now = (cnt_inc >= n_eff);
   assign sq_full  = (2*SAMPLE_BITS)'(req_sample) * (2*SAMPLE_BITS)'(req_sample);

   logic                          p_valid_ff;
   logic                          p_last_ff;
   logic signed [SAMPLE_BITS-1:0] p_sample_ff;
   logic [SSQ_W-1:0]              p_sq_ff;
   logic [LEN_W-1:0]              p_n_ff;

   // a group end waits until the previous group has left the math path
   assign req_ready = ~last_now | (cmd.idle & ~(p_valid_ff & p_last_ff));
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
         if (accept) begin
            cnt_ff <= last_now ? '0 : cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_last_ff   <= last_now;
         p_sample_ff <= req_sample;
         p_sq_ff     <= sq_full[SSQ_W-1:0];
         p_n_ff      <= cnt_inc;
      end
   end

   // ---------------- accumulate stage ----------------
   logic signed [SUM_W-1:0] acc_sum_ff;
   logic [SQ_W-1:0]         acc_sq_ff;
   logic signed [SUM_W-1:0] sum_new;
   logic [SQ_W-1:0]         sq_new;
   logic signed [SUM_W-1:0] snap_sum_ff;
   logic [SQ_W-1:0]         snap_sq_ff;
   logic [LEN_W-1:0]        snap_n_ff;

   assign sum_new = acc_sum_ff + SUM_W'(p_sample_ff);
   assign sq_new  = acc_sq_ff + SQ_W'(p_sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_sum_ff <= '0;
         acc_sq_ff  <= '0;
      end else if (p_valid_ff) begin
         acc_sum_ff <= p_last_ff ? '0 : sum_new;
         acc_sq_ff  <= p_last_ff ? '0 : sq_new;
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff && p_last_ff) begin
         snap_sum_ff <= sum_new;
         snap_sq_ff  <= sq_new;
         snap_n_ff   <= p_n_ff;
      end
   end

   // ---------------- end-of-group multiply / subtract ----------------
   logic [MAG_W-1:0]       mag_in;
   logic [MAG_W-1:0]       mag_ff;
   logic                   neg_ff;
   logic [NN_W-1:0]        nn_in;
   logic [NN_W-1:0]        nn_ff;
   logic [LEN_W+LO_W-1:0]  pp_lo_in;
   logic [LEN_W+LO_W-1:0]  pp_lo_ff;
   logic [LEN_W+HI_W-1:0]  pp_hi_in;
   logic [LEN_W+HI_W-1:0]  pp_hi_ff;
   logic [2*MAG_W-1:0]     sq_in;
   logic [2*MAG_W-1:0]     sq_ff;
   logic [PROD_W-1:0]      dnum_in;
   logic [PROD_W-1:0]      dnum_ff;

   always_comb begin
      mag_in   = snap_sum_ff[SUM_W-1] ? MAG_W'($unsigned(-snap_sum_ff))
                                      : MAG_W'($unsigned(snap_sum_ff));
      nn_in    = NN_W'(snap_n_ff) * NN_W'(snap_n_ff);
      pp_lo_in = (LEN_W+LO_W)'(snap_n_ff) * (LEN_W+LO_W)'(snap_sq_ff[LO_W-1:0]);
      pp_hi_in = (LEN_W+HI_W)'(snap_n_ff) * (LEN_W+HI_W)'(snap_sq_ff[SQ_W-1:LO_W]);
      sq_in    = (2*MAG_W)'(mag_ff) * (2*MAG_W)'(mag_ff);
      // n*sumsq >= sum^2, so the difference is exact modulo 2^PROD_W
      dnum_in  = PROD_W'({pp_hi_ff, {LO_W{1'b0}}}) + PROD_W'(pp_lo_ff)
                 - PROD_W'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         mag_ff   <= mag_in;
         neg_ff   <= snap_sum_ff[SUM_W-1];
         nn_ff    <= nn_in;
         pp_lo_ff <= pp_lo_in;
      end
      if (cmd.mul2) begin
         sq_ff    <= sq_in;
         pp_hi_ff <= pp_hi_in;
      end
      if (cmd.sub) begin
         dnum_ff  <= dnum_in;
      end
   end

   // ---------------- dividers ----------------
   logic              mean_busy;
   logic              var_busy;
   logic [MNUM_W-1:0] mean_q;
   logic [VNUM_W-1:0] var_q;

   gmv_div #(
      .NUM_W (MNUM_W),
      .DEN_W (LEN_W)
   ) u_mean_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (MNUM_W'(mag_ff) << FRAC_BITS),
      .den   (snap_n_ff),
      .busy  (mean_busy),
      .quo   (mean_q)
   );

   gmv_div #(
      .NUM_W (VNUM_W),
      .DEN_W (NN_W)
   ) u_var_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (VNUM_W'(dnum_ff) << FRAC_BITS),
      .den   (nn_ff),
      .busy  (var_busy),
      .quo   (var_q)
   );

   assign status.group_done = p_valid_ff & p_last_ff;
   assign status.div_busy   = mean_busy | var_busy;

   // ---------------- result register ----------------
   logic [MEAN_W-1:0] mean_mag;
   logic [MEAN_W-1:0] mean_in;
   logic [MEAN_W-1:0] mean_out_ff;
   logic [VAR_W-1:0]  var_out_ff;

   assign mean_mag = MEAN_W'(mean_q);
   assign mean_in  = neg_ff ? (~mean_mag + MEAN_W'(1)) : mean_mag;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mean_out_ff <= mean_in;
         var_out_ff  <= VAR_W'(var_q);
      end
   end

   assign rsp_mean_value     = $signed(mean_out_ff);
   assign rsp_variance_value = var_out_ff;

endmodule

// ===== rtl/core/group_mean_variance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_mean_variance
// Per-group mean and population variance of a stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write group_length (samples per group; 0 reads as 1, values
//            above MAX_GROUP saturate). Write only while the block is idle.
//   req_*  : one signed sample per word, taken one per cycle while req_ready is high.
//   rsp_*  : one word per finished group: mean (signed) and variance
//            (unsigned), both with FRAC_BITS fraction bits, truncated.
// Result path: after the group's last sample the snapshot is taken, then the
//   multiply, subtract and divide steps run and the result word is loaded;
//   the variance divider, one quotient bit per cycle, is the longer divider.
// Throughput: one sample per cycle. The end-of-group math runs alongside
//   the next group; the last sample of a group waits (req_ready low) while
//   the previous group is still in the math path, so short groups are
//   held to the pace of the end-of-group math.
// Reset: group_length returns to 1, accumulators and counters clear.
// A stalled rsp_ready holds the result word; the next group's math then
//   waits for the result register before finishing.
// ----------------------------------------------------------------------------
module group_mean_variance #(
   parameter int SAMPLE_BITS = gmv_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_GROUP   = gmv_pkg::MAX_GROUP_DEF,
   parameter int FRAC_BITS   = gmv_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gmv_pkg::LEN_W-1:0]         csr_group_length,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [gmv_pkg::MEAN_W-1:0] rsp_mean_value,
   output logic [gmv_pkg::VAR_W-1:0]         rsp_variance_value
);

   gmv_pkg::ctrl_cmd_type  cmd;
   gmv_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   gmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid)
   );

   gmv_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_GROUP   (MAX_GROUP),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_group_length   (csr_group_length),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_variance_value (rsp_variance_value)
   );

endmodule
